>>> sv/lsee_pkg.sv
// Shared types, register codes and field widths for the LSB sample embed/extract block.
// No dependencies; imported by every other file of the block.
`default_nettype none

package lsee_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register index codes, taken from paddr[2].
    localparam logic REG_BITS_MODE = 1'b0;
    localparam logic REG_DIRECTION = 1'b1;

    typedef enum logic {
        DIR_EMBED   = 1'b0,
        DIR_EXTRACT = 1'b1
    } dir_t;

    typedef struct packed {
        logic [MODE_W-1:0] bits_mode;
        dir_t              direction;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_in;
        logic [BYTE_W-1:0]   data_byte;
        logic                data_valid;
        logic                block_start;
    } item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        logic [BYTE_W-1:0]   byte_out;
        logic                byte_ready;
    } res_t;

endpackage

`default_nettype wire

>>> sv/lsee_cfg.sv
// APB-style configuration registers: bits_mode and direction.
// Depends on lsee_pkg.
`default_nettype none

module lsee_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lsee_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [lsee_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [lsee_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output lsee_pkg::cfg_t                        cfg
);
    import lsee_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_BITS_MODE: cfg_next.bits_mode = pwdata[MODE_W-1:0];
                REG_DIRECTION: cfg_next.direction = dir_t'(pwdata[0]);
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{bits_mode: '0, direction: DIR_EMBED};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_BITS_MODE: prdata[MODE_W-1:0] = cfg_reg.bits_mode;
            REG_DIRECTION: prdata[0]          = cfg_reg.direction;
            default:       prdata             = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> sv/lsee_core.sv
// Per-sample embed/extract datapath with the group state (shift byte, chunk position).
// Depends on lsee_pkg.
`default_nettype none

module lsee_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            accept,
    input  wire lsee_pkg::item_t item,
    input  wire lsee_pkg::cfg_t  cfg,
    output lsee_pkg::res_t       res
);
    import lsee_pkg::*;

    logic [BYTE_W-1:0] shift_reg;
    logic [BYTE_W-1:0] shift_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;

    logic [POS_W-1:0]  pos_cur;
    logic [POS_W-1:0]  last_pos;
    logic [3:0]        nbits;
    logic [BYTE_W-1:0] cmask;
    logic [BYTE_W-1:0] src;
    logic [BYTE_W-1:0] chunk;
    logic              is_last;

    always_comb begin
        nbits    = 4'd1 << cfg.bits_mode;
        cmask    = BYTE_W'((9'd1 << nbits) - 9'd1);
        last_pos = POS_W'((4'd8 >> cfg.bits_mode) - 4'd1);
        pos_cur  = item.block_start ? '0 : pos_reg;
        is_last  = pos_cur >= last_pos;

        // The byte to embed is latched on the first sample of a group.
        src   = (pos_cur == '0) ? item.data_byte : shift_reg;
        chunk = (src >> (4'd8 - nbits)) & cmask;

        res.sample_out = item.sample_in;
        res.byte_out   = '0;
        res.byte_ready = 1'b0;
        shift_next     = shift_reg;
        pos_next       = pos_cur;

        if (item.data_valid) begin
            if (cfg.direction == DIR_EMBED) begin
                shift_next     = src << nbits;
                res.sample_out = {item.sample_in[SAMPLE_W-1:BYTE_W],
                                  (item.sample_in[BYTE_W-1:0] & ~cmask) | chunk};
            end else begin
                shift_next = (shift_reg << nbits) | (item.sample_in[BYTE_W-1:0] & cmask);
                if (is_last) begin
                    res.byte_out   = shift_next;
                    res.byte_ready = 1'b1;
                end
            end
            pos_next = is_last ? '0 : pos_cur + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= '0;
            pos_reg   <= '0;
        end else if (accept) begin
            shift_reg <= shift_next;
            pos_reg   <= pos_next;
        end
    end

    // A completed byte always closes its group.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res.byte_ready |=> pos_reg == '0)
        else $error("group position not cleared after a completed byte");

    // A sample without data and without a realign leaves the state alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !item.data_valid && !item.block_start
        |=> $stable(pos_reg) && $stable(shift_reg))
        else $error("state moved on a pass-through sample");

    // A realign on a sample without data puts the position back to the start of a group.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && item.block_start && !item.data_valid |=> pos_reg == '0)
        else $error("realign without data did not clear the group position");

endmodule

`default_nettype wire

>>> sv/lsb_sample_embed_extract_top.sv
// Top level of the LSB sample embed/extract block: stream ports, APB registers, result register.
// Depends on lsee_pkg, lsee_cfg and lsee_core.
// A result appears on the master side in the cycle after its beat is accepted.
// One beat per cycle while the sink keeps m_tready high; the single result register refills in the cycle it drains.
// The only loop is the group state (shift byte, position), updated once per accepted beat.
// Reset (aresetn low, synchronous): registers, group state and the result valid flag clear.
`default_nettype none

module lsb_sample_embed_extract_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input stream.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [23:0]                         s_tdata,  // [15:0] sample_in, [23:16] data_byte
    input  wire logic [1:0]                          s_tuser,  // [0] data_valid, [1] block_start
    // Result stream.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [23:0]                         m_tdata,  // [15:0] sample_out, [23:16] byte_out
    output logic                                     m_tuser,  // [0] byte_ready
    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lsee_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [lsee_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [lsee_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready
);
    import lsee_pkg::*;

    cfg_t  cfg;
    item_t item;
    res_t  res;
    res_t  out_reg;
    logic  out_valid_reg;
    logic  out_valid_next;
    logic  s_accept;

    // Unpack the incoming beat into its fields.
    assign item.sample_in   = s_tdata[SAMPLE_W-1:0];
    assign item.data_byte   = s_tdata[SAMPLE_W+BYTE_W-1:SAMPLE_W];
    assign item.data_valid  = s_tuser[0];
    assign item.block_start = s_tuser[1];

    // The result register may be refilled in the same cycle its beat is taken.
    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    lsee_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lsee_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .item    (item),
        .cfg     (cfg),
        .res     (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (s_accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload register carries no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.byte_out, out_reg.sample_out};
    assign m_tuser  = out_reg.byte_ready;

    // A result held back by the sink must block the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while the result register is stalled");

    // Every accepted beat produces a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted beat did not reach the result register");

    // A result with no new beat behind it leaves once taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !s_accept |=> !m_tvalid)
        else $error("result repeated after it was taken");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for lsb_sample_embed_extract_top: stream beats in and out, APB writes.
// Depends on lsee_pkg and the block's RTL; a scoreboard class predicts every result beat.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lsee_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] ADDR_BITS_MODE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_DIRECTION = 3'd4;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int PHASES    = 16;
    localparam int PER_PHASE = 112;
    localparam int MAX_IDLE  = 10;

    // Models the carrier byte of each sample: hides data bits in the low chunk on embed,
    // gathers them into a byte on extract, and keeps the expected beats in arrival order.
    class lsb_scoreboard;
        logic [MODE_W-1:0] bits_mode;
        dir_t              direction;
        logic [BYTE_W-1:0] shift_byte;
        logic [POS_W-1:0]  chunk_pos;
        res_t              expected_q[$];
        int                failures;

        function new();
            bits_mode  = '0;
            direction  = DIR_EMBED;
            shift_byte = '0;
            chunk_pos  = '0;
            failures   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // A register write never touches the group state.
        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
            if (addr == ADDR_BITS_MODE) begin
                bits_mode = value[MODE_W-1:0];
            end else if (addr == ADDR_DIRECTION) begin
                direction = dir_t'(value[0]);
            end
        endfunction

        function void note_beat(item_t it);
            int   nbits;
            int   cmask;
            int   last_pos;
            int   acc;
            int   chunk;
            logic is_last;
            res_t want;
            nbits    = 1 << bits_mode;
            cmask    = (1 << nbits) - 1;
            last_pos = (8 >> bits_mode) - 1;
            want.sample_out = it.sample_in;
            want.byte_out   = '0;
            want.byte_ready = 1'b0;
            if (it.block_start) begin
                chunk_pos = '0;
            end
            if (it.data_valid) begin
                is_last = (int'(chunk_pos) >= last_pos);
                acc     = shift_byte;
                if (direction == DIR_EMBED) begin
                    if (chunk_pos == '0) begin
                        acc = it.data_byte;
                    end
                    chunk = (acc >> (8 - nbits)) & cmask;
                    acc   = (acc << nbits) & 8'hFF;
                    want.sample_out[7:0] = BYTE_W'((int'(it.sample_in[7:0]) & ~cmask) | chunk);
                end else begin
                    acc = ((acc << nbits) | (int'(it.sample_in[7:0]) & cmask)) & 8'hFF;
                    if (is_last) begin
                        want.byte_out   = BYTE_W'(acc);
                        want.byte_ready = 1'b1;
                    end
                end
                shift_byte = BYTE_W'(acc);
                chunk_pos  = is_last ? '0 : chunk_pos + 1'b1;
            end
            expected_q.push_back(want);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected result beat: sample_out %h byte_out %h byte_ready %b",
                             got.sample_out, got.byte_out, got.byte_ready);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.sample_out !== want.sample_out || got.byte_out !== want.byte_out ||
                got.byte_ready !== want.byte_ready) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch: sample_out %h/%h byte_out %h/%h byte_ready %b/%b (exp/act)",
                             want.sample_out, got.sample_out, want.byte_out, got.byte_out,
                             want.byte_ready, got.byte_ready);
                end
            end
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata  = '0;   // [15:0] sample_in, [23:16] data_byte
    logic [1:0]            s_tuser  = '0;   // [0] data_valid, [1] block_start
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;         // [15:0] sample_out, [23:16] byte_out
    logic                  m_tuser;         // [0] byte_ready
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // When set, neither side inserts idle cycles, so beats flow back to back.
    logic                  quiet    = 1'b0;
    int unsigned           cycle_count = 0;
    lsb_scoreboard         sb = new();

    lsb_sample_embed_extract_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result beat ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Presents one sample beat after a random gap and returns at the edge that accepts it.
    // The valid line is only lowered when a gap is drawn, so back-to-back beats keep it high.
    task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic [BYTE_W-1:0] data,
                               input logic valid, input logic start);
        int    gap;
        item_t it;
        gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
        it.sample_in   = sample;
        it.data_byte   = data;
        it.data_valid  = valid;
        it.block_start = start;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {data, sample};
        s_tuser  <= {start, valid};
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(it);
    endtask

    // Holds the sender off until every predicted beat has come back, then lets the
    // result register settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Two-phase APB write. The leading edge keeps psel from being lowered and raised
    // in the same step when writes follow one another.
    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(addr, value);
    endtask

    // Changes both registers while the block is idle. The upper data bits are random,
    // since only the low bits of each register are meant to be taken.
    task automatic configure(input logic [MODE_W-1:0] mode, input dir_t dir);
        logic [CFG_DATA_W-1:0] mode_word;
        logic [CFG_DATA_W-1:0] dir_word;
        mode_word = $urandom;
        dir_word  = $urandom;
        mode_word[MODE_W-1:0] = mode;
        dir_word[0] = dir;
        wait_drained();
        if ($urandom_range(0, 1) == 0) begin
            apb_write(ADDR_BITS_MODE, mode_word);
            apb_write(ADDR_DIRECTION, dir_word);
        end else begin
            apb_write(ADDR_DIRECTION, dir_word);
            apb_write(ADDR_BITS_MODE, mode_word);
        end
    endtask

    // Result side: a random stall before each beat, then the beat is checked at the
    // edge that takes it. The ready line stays high when no stall is drawn.
    initial begin
        int   stall;
        res_t got;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.sample_out = m_tdata[15:0];
            got.byte_out   = m_tdata[23:16];
            got.byte_ready = m_tuser;
            sb.check_result(got);
        end
    end

    initial begin
        logic [MODE_W-1:0] mode;
        dir_t              dir;
        int                done;
        int                in_group;
        int                group_len;
        logic              start;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. Reset settings first: one bit per sample, embed.
        send_sample(16'hFFFF, 8'hA5, 1'b1, 1'b1);
        send_sample(16'h0000, 8'h5A, 1'b1, 1'b0);

        // Whole low byte replaced; one sample per group, so every beat latches a byte.
        // A sample without valid data passes unchanged even with block_start set.
        configure(2'd3, DIR_EMBED);
        send_sample(16'hFFFF, 8'h00, 1'b1, 1'b1);
        send_sample(16'h0000, 8'hFF, 1'b1, 1'b0);
        send_sample(16'h1234, 8'h55, 1'b0, 1'b1);

        // Whole-byte extraction: a byte is ready on every valid sample.
        configure(2'd3, DIR_EXTRACT);
        send_sample(16'h00FF, 8'h00, 1'b1, 1'b1);
        send_sample(16'hFF00, 8'hFF, 1'b1, 1'b0);

        // One bit per sample: five bits in, a realign on an invalid sample that must hold
        // the assembly byte, two more bits, then a switch to four bits per sample while
        // the position already lies beyond the new group's end.
        configure(2'd0, DIR_EXTRACT);
        send_sample(16'h0001, 8'h00, 1'b1, 1'b1);
        send_sample(16'hFFFE, 8'hFF, 1'b1, 1'b0);
        send_sample(16'h0001, 8'h00, 1'b1, 1'b0);
        send_sample(16'h5555, 8'h00, 1'b1, 1'b0);
        send_sample(16'hAAAA, 8'h00, 1'b1, 1'b0);
        send_sample(16'hABCD, 8'h00, 1'b0, 1'b1);
        send_sample(16'h0001, 8'h00, 1'b1, 1'b0);
        send_sample(16'h0001, 8'h00, 1'b1, 1'b0);
        configure(2'd2, DIR_EXTRACT);
        send_sample(16'h0F0F, 8'h00, 1'b1, 1'b0);

        // Mid-group switch while embedding: the next chunk comes from what is left of
        // the latched byte rather than from a fresh one.
        configure(2'd2, DIR_EMBED);
        send_sample(16'h8000, 8'hC3, 1'b1, 1'b1);
        configure(2'd3, DIR_EMBED);
        send_sample(16'h00FF, 8'h3C, 1'b1, 1'b0);

        // Two bits per sample, one full group extracted.
        configure(2'd1, DIR_EXTRACT);
        send_sample(16'hFFFF, 8'h00, 1'b1, 1'b1);
        send_sample(16'h0000, 8'h00, 1'b1, 1'b0);
        send_sample(16'h0002, 8'h00, 1'b1, 1'b0);
        send_sample(16'h0001, 8'h00, 1'b1, 1'b0);

        // Random part. The first eight phases walk every mode in both directions, the rest
        // draw settings at random. Most beats form well-aligned groups; the rest are
        // samples without data and stray or missing block_start marks.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 8) begin
                mode = MODE_W'(phase % 4);
                dir  = dir_t'(phase / 4);
            end else begin
                mode = MODE_W'($urandom_range(0, 3));
                dir  = dir_t'($urandom_range(0, 1));
            end
            configure(mode, dir);
            quiet     = (phase % 4 == 3);
            group_len = 8 >> mode;
            done      = 0;
            in_group  = 0;
            while (done < PER_PHASE) begin
                if (phase == 5 && done == PER_PHASE / 2) begin
                    wait_drained();
                end
                if ($urandom_range(0, 99) < 8) begin
                    start = $urandom_range(0, 1);
                    if (start) begin
                        in_group = 0;
                    end
                    send_sample(16'($urandom), 8'($urandom), 1'b0, start);
                end else begin
                    if (in_group == 0) begin
                        start = ($urandom_range(0, 9) != 0);
                    end else begin
                        start = ($urandom_range(0, 29) == 0);
                    end
                    if (start) begin
                        in_group = 0;
                    end
                    send_sample(16'($urandom), 8'($urandom), 1'b1, start);
                    in_group = (in_group + 1) % group_len;
                    done++;
                end
            end
        end

        // Let the last beats come back, then give the result register time to show
        // anything it should not.
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
sv/lsee_pkg.sv
sv/lsee_cfg.sv
sv/lsee_core.sv
sv/lsb_sample_embed_extract_top.sv
tb/tb_top.sv
